// ===== rtl/core/gplp_pkg.sv =====
// Shared types, register codes and arithmetic helpers of the load partitioner.
`default_nettype none
package gplp_pkg;

	localparam int MAX_PROCS_DEF = 64;
	localparam int ID_BITS_DEF   = 16;

	localparam int PROC_W   = 6;
	localparam int NPROC_W  = 7;
	localparam int MASK_W   = 64;
	localparam int LOAD_W   = 32;
	localparam int ACC_W    = 48;
	localparam int TGT_W    = 54;
	localparam int ERR_W    = 55;
	localparam int CNT_W    = 16;
	localparam int ID_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_PROCS  = 2'd0,
		CFG_AVAIL_MASK = 2'd1,
		CFG_LOAD_SHARE = 2'd2,
		CFG_MAX_PIECES = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [NPROC_W-1:0] num_procs;
		logic [MASK_W-1:0]  available_mask;
		logic [ACC_W-1:0]   load_share;
		logic [CNT_W-1:0]   max_pieces;
	} cfg_t;

	typedef struct packed {
		logic              found;
		logic [PROC_W-1:0] proc;
	} pick_t;

	function automatic logic [ACC_W-1:0] sat48(input logic [ACC_W:0] v);
		return v[ACC_W] ? ACC_MAX : v[ACC_W-1:0];
	endfunction

	function automatic logic [ERR_W-1:0] absdiff(input logic [ERR_W-1:0] a,
		input logic [ERR_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gplp_cfg.sv =====
// Configuration register file of the load partitioner.
`default_nettype none
module gplp_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [gplp_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [gplp_pkg::MASK_W-1:0]      wr_data,
	output gplp_pkg::cfg_t                        cfg
);
	import gplp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_procs      <= NPROC_W'(64);
			cfg_q.available_mask <= '1;
			cfg_q.load_share     <= '0;
			cfg_q.max_pieces     <= CNT_W'(1);
		end else if (wr_en) begin
			case (wr_index)
				CFG_NUM_PROCS:  cfg_q.num_procs      <= wr_data[NPROC_W-1:0];
				CFG_AVAIL_MASK: cfg_q.available_mask <= wr_data;
				CFG_LOAD_SHARE: cfg_q.load_share     <= wr_data[ACC_W-1:0];
				CFG_MAX_PIECES: cfg_q.max_pieces     <= wr_data[CNT_W-1:0];
				default:        cfg_q                <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/core/gplp_pick.sv =====
// Lowest available processor at or above a start index.
`default_nettype none
module gplp_pick #(
	parameter int MAX_PROCS = gplp_pkg::MAX_PROCS_DEF
) (
	input  wire logic [gplp_pkg::MASK_W-1:0]  available_mask,
	input  wire logic [gplp_pkg::NPROC_W-1:0] num_procs,
	input  wire logic [gplp_pkg::NPROC_W-1:0] start,
	output gplp_pkg::pick_t                   pick
);
	import gplp_pkg::*;

	localparam logic [NPROC_W-1:0] MaxProcs = NPROC_W'(MAX_PROCS);

	logic [NPROC_W-1:0] limit;
	logic [MASK_W-1:0]  cand;
	logic [MASK_W-1:0]  lowest;
	logic [PROC_W-1:0]  idx;

	assign limit = (num_procs < MaxProcs) ? num_procs : MaxProcs;

	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			cand[i] = available_mask[i] && (NPROC_W'(i) < limit) && (NPROC_W'(i) >= start);
		end
	end

	assign lowest = cand & (~cand + MASK_W'(1));

	always_comb begin
		idx = '0;
		for (int i = 0; i < MASK_W; i++) begin
			idx = idx | ({PROC_W{lowest[i]}} & PROC_W'(i));
		end
	end

	assign pick.found = |cand;
	assign pick.proc  = idx;

endmodule
`default_nettype wire

// ===== rtl/core/gplp_core.sv =====
// Partition state and the join-or-open decision for one piece.
`default_nettype none
module gplp_core #(
	parameter int MAX_PROCS = gplp_pkg::MAX_PROCS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  gplp_pkg::cfg_t                    cfg,
	input  wire logic                         step,
	input  wire logic [gplp_pkg::LOAD_W-1:0]  load,
	input  wire logic                         first,
	output logic [gplp_pkg::PROC_W-1:0]       proc,
	output logic                              flagged
);
	import gplp_pkg::*;

	logic [PROC_W-1:0] cur_q;
	logic [CNT_W-1:0]  pieces_q;
	logic [ACC_W-1:0]  lb_q;
	logic [ACC_W-1:0]  lc_q;
	logic [TGT_W-1:0]  target_q;
	logic [ERR_W-1:0]  best_q;
	logic              run_q;
	logic              exh_q;

	logic               start_new;
	logic [ACC_W+1:0]   join_sum;
	logic [ERR_W-1:0]   join_err;
	logic               join_ok;
	logic               do_open;
	logic [ACC_W-1:0]   lb_open;
	logic [NPROC_W-1:0] start;
	pick_t              pick;
	logic [NPROC_W-1:0] proc_plus;
	logic [TGT_W-1:0]   target_open;
	logic [ACC_W:0]     open_sum;
	logic [ERR_W-1:0]   open_err;

	assign start_new = first || !run_q;
	assign join_sum  = {2'b0, lb_q} + {2'b0, lc_q} + (ACC_W+2)'(load);
	assign join_err  = absdiff(ERR_W'(join_sum), ERR_W'(target_q));
	assign join_ok   = !start_new && !exh_q && (pieces_q < cfg.max_pieces)
		&& (join_err < best_q);
	assign do_open   = start_new || (!exh_q && !join_ok);
	assign lb_open   = start_new ? '0 : sat48({1'b0, lb_q} + {1'b0, lc_q});
	assign start     = start_new ? '0 : (NPROC_W'(cur_q) + NPROC_W'(1));

	gplp_pick #(
		.MAX_PROCS (MAX_PROCS)
	) u_pick (
		.available_mask (cfg.available_mask),
		.num_procs      (cfg.num_procs),
		.start          (start),
		.pick           (pick)
	);

	assign proc_plus   = NPROC_W'(pick.proc) + NPROC_W'(1);
	assign target_open = TGT_W'(proc_plus * cfg.load_share);
	assign open_sum    = {1'b0, lb_open} + (ACC_W+1)'(load);
	assign open_err    = absdiff(ERR_W'(open_sum), ERR_W'(target_open));

	always_comb begin
		flagged = (!start_new && exh_q) || (do_open && !pick.found);
		if (flagged) begin
			proc = '0;
		end else if (do_open) begin
			proc = pick.proc;
		end else begin
			proc = cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			pieces_q <= '0;
			lb_q     <= '0;
			lc_q     <= '0;
			target_q <= '0;
			best_q   <= '0;
			run_q    <= 1'b0;
			exh_q    <= 1'b0;
		end else if (step) begin
			run_q <= 1'b1;
			if (do_open) begin
				lb_q  <= lb_open;
				exh_q <= !pick.found;
				if (pick.found) begin
					cur_q    <= pick.proc;
					pieces_q <= CNT_W'(1);
					lc_q     <= ACC_W'(load);
					target_q <= target_open;
					best_q   <= open_err;
				end
			end else if (join_ok) begin
				lc_q     <= sat48({1'b0, lc_q} + (ACC_W+1)'(load));
				pieces_q <= pieces_q + CNT_W'(1);
				best_q   <= join_err;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/greedy_prefix_load_partitioner.sv =====
// Top level of the greedy prefix-sum load partitioner.
//
// Pieces arrive on the input channel (in_valid/in_ready) in curve order, one
// transfer each. Every piece yields exactly one result transfer on the output
// channel (out_valid/out_ready) carrying its id, the chosen processor and an
// out_of_procs flag. A piece sits in an input register while the join-or-open
// decision is made, then lands in the result register, so both registers lie
// between an input transfer and its result transfer. While out_ready is high
// one piece per cycle is sustained; the rate is set by the combinational
// decision loop on the partition state (priority pick, 7x48 target multiply,
// absolute-difference compare). When out_ready is low the result holds, the
// input register fills, and in_ready drops until the result is taken; nothing
// is dropped. Reset clears the partition state and loads the default
// registers; the first piece after reset starts a run. Registers are written
// on the cfg channel (cfg_valid/cfg_ready, always ready) only while no piece is
// in flight, a rule for the user that the block itself does not enforce.
`default_nettype none
module greedy_prefix_load_partitioner #(
	parameter int MAX_PROCS = gplp_pkg::MAX_PROCS_DEF,
	parameter int ID_BITS   = gplp_pkg::ID_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [gplp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [gplp_pkg::MASK_W-1:0]      cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [gplp_pkg::LOAD_W-1:0]      piece_load,
	input  wire logic [gplp_pkg::ID_W-1:0]        object_id,
	input  wire logic                             first_piece,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [gplp_pkg::ID_W-1:0]             result_id,
	output logic [gplp_pkg::PROC_W-1:0]           assigned_proc,
	output logic                                  out_of_procs
);
	import gplp_pkg::*;

	localparam int IdW = (ID_BITS < ID_W) ? ID_BITS : ID_W;

	cfg_t              cfg_q;
	logic              in_fire;
	logic              res_load;
	logic              s1_valid_q;
	logic [LOAD_W-1:0] load_s1;
	logic [IdW-1:0]    id_s1;
	logic              first_s1;
	logic              out_valid_q;
	logic [IdW-1:0]    res_id_q;
	logic [PROC_W-1:0] res_proc_q;
	logic              res_flag_q;
	logic [PROC_W-1:0] dec_proc;
	logic              dec_flag;

	assign cfg_ready = 1'b1;

	gplp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg_q)
	);

	assign res_load = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || res_load;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (res_load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			load_s1  <= piece_load;
			id_s1    <= IdW'(object_id);
			first_s1 <= first_piece;
		end
	end

	gplp_core #(
		.MAX_PROCS (MAX_PROCS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.step    (res_load),
		.load    (load_s1),
		.first   (first_s1),
		.proc    (dec_proc),
		.flagged (dec_flag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_id_q   <= id_s1;
			res_proc_q <= dec_proc;
			res_flag_q <= dec_flag;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_id     = ID_W'(res_id_q);
	assign assigned_proc = res_proc_q;
	assign out_of_procs  = res_flag_q;

	a_flag_proc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_procs |-> assigned_proc == '0)
		else $error("flagged result carries a processor");

	a_proc_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_of_procs |->
			cfg_q.available_mask[assigned_proc] &&
			(NPROC_W'(assigned_proc) < cfg_q.num_procs))
		else $error("assigned processor not available");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_valid_q |=> out_valid_q)
		else $error("held piece not moved to result register");

endmodule
`default_nettype wire
